// File: hw/rtl/rhs_pkg.sv
package rhs_pkg;

  // Stream payload widths
  localparam int unsigned CntW     = 16;
  localparam int unsigned AgeW     = 32;
  localparam int unsigned InW      = 48;
  localparam int unsigned ScoreW   = 7;
  localparam int unsigned OutW     = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WeightW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxAccesses = 3'd0,
    CfgIntervalUs  = 3'd1,
    CfgFreqWeight  = 3'd2,
    CfgAgeWeight   = 3'd3,
    CfgColdMode    = 3'd4
  } cfg_idx_e;

  // Scoring constants
  localparam int unsigned SubscoreMax = 100;
  localparam int unsigned AgeLogCap   = 32;
  localparam longint unsigned UsecPerSec = 64'd1000000;
  localparam int unsigned MaxScore    = 99;

  // Internal datapath widths
  localparam int unsigned FreqW    = 7;
  localparam int unsigned CnumW    = 23;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned LgW      = 6;
  localparam int unsigned OffW     = 7;
  localparam int unsigned AgeMulW  = 13;
  localparam int unsigned NumW     = 24;
  localparam int unsigned WsumW    = 17;
  localparam int unsigned XW       = 17;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW   = 18;
  localparam int unsigned Recip    = ((1 << RecipShift) + SubscoreMax - 1) / SubscoreMax;
  localparam int unsigned YW       = XW + RecipW;
  localparam int unsigned HotW     = YW - RecipShift;

endpackage

// File: hw/rtl/region_hotness_score_top.sv
// Region hotness scorer, 22 register stages from request to result.
// One request is accepted every cycle, sustained, while the master side takes
// each score; a low m_axis_tready can stall the pipeline back to the input.
// Most of the depth is in the two restoring dividers, one quotient bit per stage.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores the
// configuration registers to their defaults.
module region_hotness_score_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rhs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rhs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rhs_pkg::InW-1:0]       s_axis_tdata,  // access_count, region_age
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rhs_pkg::OutW-1:0]      m_axis_tdata   // score, zero pad
);
  import rhs_pkg::*;

  function automatic logic [AgeLogCap-1:0] age_therm(input logic [ProdW-1:0] prod);
    logic [AgeLogCap-1:0] t;
    for (int k = 0; k < AgeLogCap; k++) begin
      t[k] = prod >= (UsecPerSec << k);
    end
    return t;
  endfunction

  // Configuration registers
  logic [CntW-1:0]    max_acc_q;
  logic [AgeW-1:0]    interval_q;
  logic [WeightW-1:0] freq_w_q;
  logic [WeightW-1:0] age_w_q;
  logic               cold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_acc_q  <= CntW'(20);
      interval_q <= AgeW'(100000);
      freq_w_q   <= WeightW'(1);
      age_w_q    <= WeightW'(1);
      cold_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMaxAccesses: max_acc_q  <= cfg_wdata_i[CntW-1:0];
        CfgIntervalUs:  interval_q <= cfg_wdata_i[AgeW-1:0];
        CfgFreqWeight:  freq_w_q   <= cfg_wdata_i[WeightW-1:0];
        CfgAgeWeight:   age_w_q    <= cfg_wdata_i[WeightW-1:0];
        CfgColdMode:    cold_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0]  maxc;
  logic [WsumW-1:0] wsum;
  assign maxc = (max_acc_q == '0) ? CntW'(1) : max_acc_q;
  assign wsum = WsumW'(freq_w_q) + WsumW'(age_w_q);

  logic [CntW-1:0] in_count;
  logic [AgeW-1:0] in_age;
  assign in_count = s_axis_tdata[CntW-1:0];
  assign in_age   = s_axis_tdata[CntW +: AgeW];

  // Pipeline state
  logic v1_q, v2_q, va_q, vb_q, vc_q, vd_q, ve_q, vf_q;
  logic en1, en2, ena, enb, enc, end_, ene, enf;
  logic div1_rdy, div2_rdy, div1_v, div2_v;

  logic [CntW-1:0]      c1_q;
  logic [AgeW-1:0]      age1_q;
  logic [CnumW-1:0]     cn2_q;
  logic [ProdW-1:0]     prod2_q;
  logic [FreqW-1:0]     div1_quot;
  logic [AgeLogCap-1:0] div1_side;
  logic [FreqW-1:0]     freqa_q;
  logic [LgW-1:0]       lga_q;
  logic [FreqW-1:0]     freqb_q;
  logic [FreqW-1:0]     agesubb_q;
  logic [NumW-1:0]      numc_q;
  logic [FreqW-1:0]     div2_quot;
  logic                 div2_side;
  logic [XW-1:0]        xd_q;
  logic [YW-1:0]        ye_q;
  logic [ScoreW-1:0]    scoref_q;

  logic [OffW-1:0]    off_b;
  logic [AgeMulW-1:0] agemul_b;
  logic [HotW-1:0]    hot_f;
  logic [HotW-1:0]    score_d;

  // Each stage advances when empty or when the next one advances
  assign enf = ~vf_q | m_axis_tready;
  assign ene = ~ve_q | enf;
  assign end_ = ~vd_q | ene;
  assign enc = ~vc_q | div2_rdy;
  assign enb = ~vb_q | enc;
  assign ena = ~va_q | enb;
  assign en2 = ~v2_q | div1_rdy;
  assign en1 = ~v1_q | en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= s_axis_tvalid;
      if (en2)  v2_q <= v1_q;
      if (ena)  va_q <= div1_v;
      if (enb)  vb_q <= va_q;
      if (enc)  vc_q <= vb_q;
      if (end_) vd_q <= div2_v;
      if (ene)  ve_q <= vd_q;
      if (enf)  vf_q <= ve_q;
    end
  end

  always_comb begin
    off_b = (freqa_q == '0) ? OffW'(AgeLogCap) - OffW'(lga_q)
                            : OffW'(AgeLogCap) + OffW'(lga_q);
    agemul_b = AgeMulW'(off_b) * AgeMulW'(SubscoreMax);
    hot_f    = ye_q[YW-1:RecipShift];
    score_d  = cold_q ? HotW'(MaxScore) - hot_f : hot_f;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q   <= (in_count > maxc) ? maxc : in_count;
      age1_q <= in_age;
    end
    if (en2) begin
      cn2_q   <= CnumW'(c1_q) * CnumW'(SubscoreMax);
      prod2_q <= ProdW'(age1_q) * ProdW'(interval_q);
    end
    if (ena) begin
      freqa_q <= div1_quot;
      lga_q   <= LgW'($countones(div1_side));
    end
    if (enb) begin
      freqb_q   <= freqa_q;
      agesubb_q <= agemul_b[AgeMulW-1:AgeMulW-FreqW];
    end
    if (enc) begin
      numc_q <= NumW'(freq_w_q) * NumW'(freqb_q) + NumW'(age_w_q) * NumW'(agesubb_q);
    end
    if (end_) begin
      // both weights zero: force the mean to zero
      xd_q <= div2_side ? '0 : XW'(div2_quot) * XW'(MaxScore);
    end
    if (ene) begin
      ye_q <= YW'(xd_q) * YW'(Recip);
    end
    if (enf) begin
      scoref_q <= score_d[ScoreW-1:0];
    end
  end

  // Frequency subscore: clamped count * 100 / max_accesses
  rhs_div #(
    .NumW  (CnumW),
    .DenW  (CntW),
    .QuotW (FreqW),
    .SideW (AgeLogCap)
  ) u_freq_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .ready_o (div1_rdy),
    .num_i   (cn2_q),
    .den_i   (maxc),
    .side_i  (age_therm(prod2_q)),
    .valid_o (div1_v),
    .ready_i (ena),
    .quot_o  (div1_quot),
    .side_o  (div1_side)
  );

  // Weighted mean of the two subscores
  rhs_div #(
    .NumW  (NumW),
    .DenW  (WsumW),
    .QuotW (FreqW),
    .SideW (1)
  ) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vc_q),
    .ready_o (div2_rdy),
    .num_i   (numc_q),
    .den_i   (wsum),
    .side_i  (wsum == '0),
    .valid_o (div2_v),
    .ready_i (end_),
    .quot_o  (div2_quot),
    .side_o  (div2_side)
  );

  assign m_axis_tvalid = vf_q;
  assign m_axis_tdata  = {{(OutW-ScoreW){1'b0}}, scoref_q};

endmodule

// File: hw/rtl/rhs_div.sv
module rhs_div #(
  parameter int unsigned NumW  = 23,
  parameter int unsigned DenW  = 16,
  parameter int unsigned QuotW = 7,
  parameter int unsigned SideW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [QuotW-1:0] quot_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned CmpW = (NumW > DenW + QuotW) ? NumW : DenW + QuotW;

  logic [QuotW-1:0] v_q;
  logic [QuotW-1:0] en;
  logic [NumW-1:0]  rem_q  [QuotW];
  logic [QuotW-1:0] quot_q [QuotW];
  logic [DenW-1:0]  den_q  [QuotW];
  logic [SideW-1:0] side_q [QuotW];

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int unsigned Bit = QuotW - 1 - k;

    logic             v_p;
    logic [NumW-1:0]  rem_p;
    logic [QuotW-1:0] quot_p;
    logic [DenW-1:0]  den_p;
    logic [SideW-1:0] side_p;
    logic [CmpW-1:0]  trial;
    logic [CmpW-1:0]  diff;
    logic             ge;
    logic [NumW-1:0]  rem_d;
    logic [QuotW-1:0] quot_d;

    if (k == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = num_i;
      assign quot_p = '0;
      assign den_p  = den_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign quot_p = quot_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
    end

    if (k == QuotW - 1) begin : g_last_en
      assign en[k] = ~v_q[k] | ready_i;
    end else begin : g_mid_en
      assign en[k] = ~v_q[k] | en[k+1];
    end

    always_comb begin
      trial  = CmpW'(den_p) << Bit;
      ge     = CmpW'(rem_p) >= trial;
      diff   = CmpW'(rem_p) - trial;
      rem_d  = ge ? diff[NumW-1:0] : rem_p;
      quot_d = quot_p;
      quot_d[Bit] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d;
        quot_q[k] <= quot_d;
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

// File: tb/sv/rhs_score_monitor.sv
`timescale 1ns / 1ps

module rhs_score_monitor
  import rhs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [InW-1:0]      req_data_i,
  input  logic                score_valid_i,
  input  logic                score_ready_i,
  input  logic [OutW-1:0]     score_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [15:0] max_accesses_q;
  logic [31:0] interval_us_q;
  logic [15:0] freq_weight_q;
  logic [15:0] age_weight_q;
  logic        cold_mode_q;

  logic [ScoreW-1:0] expected_scores[$];
  int                mismatches;

  function automatic logic [ScoreW-1:0] hotness_of(input logic [CntW-1:0] cnt,
                                                   input logic [AgeW-1:0] age);
    longint unsigned maxc, c, freq, secs, off, agesub;
    longint unsigned wsum, num, mean, hot, s;
    int unsigned     lg;
    maxc = (max_accesses_q == '0) ? 1 : longint'(max_accesses_q);
    c    = (longint'(cnt) > maxc) ? maxc : longint'(cnt);
    freq = c * SubscoreMax / maxc;
    secs = (64'(age) * 64'(interval_us_q)) / UsecPerSec;
    lg   = 0;
    while (secs != 0 && lg < AgeLogCap) begin
      secs = secs >> 1;
      lg++;
    end
    // offset log: shifted down when the frequency subscore is zero
    off    = (freq == 0) ? longint'(AgeLogCap - lg) : longint'(AgeLogCap + lg);
    agesub = (off * SubscoreMax / AgeLogCap) / 2;
    wsum   = longint'(freq_weight_q) + longint'(age_weight_q);
    num    = longint'(freq_weight_q) * freq + longint'(age_weight_q) * agesub;
    mean   = (wsum != 0) ? num / wsum : num;
    hot    = mean * MaxScore / SubscoreMax;
    s      = cold_mode_q ? (MaxScore - hot) : hot;
    return s[ScoreW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ScoreW-1:0] exp_score;
    if (!rst_ni) begin
      max_accesses_q = 16'd20;
      interval_us_q  = 32'd100000;
      freq_weight_q  = 16'd1;
      age_weight_q   = 16'd1;
      cold_mode_q    = 1'b0;
      expected_scores.delete();
      mismatches     = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        expected_scores.push_back(hotness_of(req_data_i[CntW-1:0],
                                             req_data_i[CntW+AgeW-1:CntW]));
      end
      if (score_valid_i && score_ready_i) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] score %0d with no request outstanding", $realtime,
                     score_data_i[ScoreW-1:0]);
          end
        end else begin
          exp_score = expected_scores.pop_front();
          if (score_data_i[ScoreW-1:0] !== exp_score) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] score mismatch: expected %0d, got %0d", $realtime,
                       exp_score, score_data_i[ScoreW-1:0]);
            end
          end
        end
      end
      // registers change only while idle, so the order against requests is moot
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgMaxAccesses: max_accesses_q = cfg_wdata_i[15:0];
          CfgIntervalUs:  interval_us_q  = cfg_wdata_i[31:0];
          CfgFreqWeight:  freq_weight_q  = cfg_wdata_i[WeightW-1:0];
          CfgAgeWeight:   age_weight_q   = cfg_wdata_i[WeightW-1:0];
          CfgColdMode:    cold_mode_q    = cfg_wdata_i[0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_scores.size();
    end
  end

endmodule

// File: tb/sv/region_hotness_score_top_tb.sv
`timescale 1ns / 1ps

module region_hotness_score_top_tb;
  import rhs_pkg::*;

  localparam int PipeDepth     = 21;
  localparam int WatchdogLimit = 2000;
  localparam int RandomPhases  = 10;
  localparam int PhaseRequests = 53;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata;   // access_count, region_age
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutW-1:0]     m_axis_tdata;   // score, zero pad

  int fail_count;
  int pending;
  int idle_cycles;
  int tx_gap_max;
  int rx_gap_max;
  int unsigned cur_max_accesses;

  region_hotness_score_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rhs_score_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .score_valid_i (m_axis_tvalid),
    .score_ready_i (m_axis_tready),
    .score_data_i  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each score
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_request(input logic [CntW-1:0] cnt, input logic [AgeW-1:0] age);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {age, cnt};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Hold off until every score is back, then let the pipeline settle
  task automatic drain_scores();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  task automatic drive_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  task automatic program_scorer(input logic [15:0] max_acc, input logic [31:0] interval,
                                input logic [15:0] freq_w, input logic [15:0] age_w,
                                input logic cold);
    drain_scores();
    drive_reg(CfgMaxAccesses, 32'(max_acc));
    drive_reg(CfgIntervalUs, interval);
    drive_reg(CfgFreqWeight, 32'(freq_w));
    drive_reg(CfgAgeWeight, 32'(age_w));
    drive_reg(CfgColdMode, 32'(cold));
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_max_accesses = (max_acc == 0) ? 1 : max_acc;
  endtask

  function automatic logic [CntW-1:0] pick_count();
    int unsigned hi;
    hi = cur_max_accesses + cur_max_accesses / 4 + 1;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CntW'($urandom);
      default: return CntW'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [AgeW-1:0] pick_age();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 16));
      3:       return 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 2;
      default: return 12;
    endcase
  endfunction

  initial begin
    logic [15:0] max_acc;
    logic [31:0] interval;
    cfg_we           = 1'b0;
    cfg_idx          = CfgMaxAccesses;
    cfg_wdata        = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    tx_gap_max       = 0;
    rx_gap_max       = 0;
    cur_max_accesses = 20;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: idle, zero and saturated counts, extreme ages
    send_request(16'd0, 32'd0);
    send_request(16'd20, 32'd0);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
    send_request(16'd10, 32'd10);
    send_request(16'd0, 32'hFFFF_FFFF);
    send_request(16'd1, 32'd1);

    // Zero maximum taken as one, longest interval, age weight off, cold
    tx_gap_max = 12;
    rx_gap_max = 12;
    program_scorer(16'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b1);
    send_request(16'd0, 32'hFFFF_FFFF);
    send_request(16'd1, 32'd5);
    send_request(16'hFFFF, 32'd1);

    // Both weights zero
    program_scorer(16'hFFFF, 32'd1, 16'd0, 16'd0, 1'b0);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
    send_request(16'd0, 32'd12345);
    send_request(16'h8000, 32'h8000_0000);

    // Age dominates, cold
    tx_gap_max = 0;
    rx_gap_max = 0;
    program_scorer(16'hFFFF, 32'd1000000, 16'd1, 16'hFFFF, 1'b1);
    send_request(16'd0, 32'd1);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
    send_request(16'd100, 32'd2);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case ($urandom_range(0, 3))
        0:       max_acc = 16'd1;
        1:       max_acc = 16'hFFFF;
        2:       max_acc = 16'($urandom_range(1, 100));
        default: max_acc = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       interval = 32'd1;
        1:       interval = 32'hFFFF_FFFF;
        2:       interval = $urandom_range(1000, 1000000);
        default: interval = $urandom_range(1, 32'hFFFF_FFFF);
      endcase
      tx_gap_max = pick_gap_max();
      rx_gap_max = pick_gap_max();
      program_scorer(max_acc, interval, pick_weight(), pick_weight(), 1'($urandom_range(0, 1)));
      for (int n = 0; n < PhaseRequests; n++) begin
        send_request(pick_count(), pick_age());
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: region_hotness_score_top.f
hw/rtl/rhs_pkg.sv
hw/rtl/rhs_div.sv
hw/rtl/region_hotness_score_top.sv
tb/sv/rhs_score_monitor.sv
tb/sv/region_hotness_score_top_tb.sv
